[hdl/vpa_pkg.sv]
// Shared types and constants for the variable partition allocator.
// Holds the transfer payload structs, status codes and the cell command format.
// No dependencies.
package vpa_pkg;

    localparam int ADDR_BITS    = 16;
    localparam int OWNER_BITS   = 8;
    localparam int MAX_PARTS_DEF = 64;
    localparam int CNT_BITS     = 7;
    localparam logic [ADDR_BITS-1:0] TOTAL_RESET = 16'hFFFF;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_COMPACT = 2'd2;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_FIT       = 3'd1,
        ST_BAD_OWNER    = 3'd2,
        ST_OWNER_EXISTS = 3'd3,
        ST_BAD_SIZE     = 3'd4,
        ST_TABLE_FULL   = 3'd5,
        ST_NOT_FOUND    = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]            func;
        logic [OWNER_BITS-1:0] owner;
        logic [ADDR_BITS-1:0]  request_size;
        logic [1:0]            strategy;
    } t_in;

    typedef struct packed {
        t_status               status;
        logic [ADDR_BITS-1:0]  alloc_start;
        logic [ADDR_BITS-1:0]  free_total;
        logic [CNT_BITS-1:0]   free_count;
        logic [ADDR_BITS-1:0]  largest_free;
        logic [CNT_BITS-1:0]   partition_count;
    } t_out;

    typedef struct packed {
        logic                  valid;
        logic [OWNER_BITS-1:0] owner;
        logic [ADDR_BITS-1:0]  start;
        logic [ADDR_BITS-1:0]  size;
    } t_entry;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROT,
        OP_SQZ,
        OP_INS,
        OP_OWN,
        OP_SET,
        OP_INIT
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic                  phase;
        logic                  merge;
        logic [ADDR_BITS-1:0]  merge_start;
        logic [ADDR_BITS-1:0]  merge_add;
        logic [OWNER_BITS-1:0] owner;
        logic [ADDR_BITS-1:0]  size;
        t_entry                entry;
    } t_cell_cmd;

endpackage

[hdl/vpa_cell.sv]
// One table slot of the partition chain: owner, start, size and a valid bit.
// Moves data to or from its neighbors as the broadcast command says.
// Depends on vpa_pkg.
module vpa_cell #(
    parameter int MAX_PARTS = vpa_pkg::MAX_PARTS_DEF,
    parameter int IDX       = 0,
    parameter int IW        = $clog2(MAX_PARTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vpa_pkg::t_cell_cmd i_cmd,
    input  logic [IW-1:0]      i_idx,
    input  vpa_pkg::t_entry    i_left,
    input  vpa_pkg::t_entry    i_right,
    output vpa_pkg::t_entry    o_q
);
    import vpa_pkg::*;

    localparam logic [IW:0] ME  = (IW+1)'(IDX);
    localparam logic        ODD = 1'(IDX % 2);

    t_entry      r_q;
    t_entry      n_q;
    logic [IW:0] w_idx0;
    logic [IW:0] w_idx1;

    assign w_idx0 = {1'b0, i_idx};
    assign w_idx1 = w_idx0 + 1'b1;
    assign o_q    = r_q;

    always_comb begin
        n_q = r_q;
        case (i_cmd.op)
            OP_ROT: begin
                n_q = i_right;
                if (IDX == 0 && i_cmd.merge) begin
                    n_q.size  = i_right.size + i_cmd.merge_add;
                    n_q.start = i_cmd.merge_start;
                end
            end
            OP_SQZ: begin
                // odd-even transposition: holes bubble toward the top
                if (ODD == i_cmd.phase) begin
                    if (IDX != MAX_PARTS-1 && !r_q.valid && i_right.valid) n_q = i_right;
                end else begin
                    if (IDX != 0 && !i_left.valid && r_q.valid) n_q = i_left;
                end
            end
            OP_INS: begin
                if (ME == w_idx0) begin
                    n_q.owner = i_cmd.owner;
                    n_q.size  = i_cmd.size;
                end else if (ME == w_idx1) begin
                    n_q = i_cmd.entry;
                end else if (ME > w_idx1) begin
                    n_q = i_left;
                end
            end
            OP_OWN: begin
                if (ME == w_idx0) n_q.owner = i_cmd.owner;
            end
            OP_SET: begin
                if (ME == w_idx0) n_q = i_cmd.entry;
            end
            OP_INIT: begin
                if (IDX == 0) n_q = i_cmd.entry;
                else          n_q.valid = 1'b0;
            end
            default: n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= (IDX == 0);
            r_q.owner <= '0;
            r_q.start <= '0;
            r_q.size  <= TOTAL_RESET;
        end else begin
            r_q <= n_q;
        end
    end

endmodule

[hdl/variable_partition_allocator_unit.sv]
// Variable partition allocator: a chain of table cells with a sequencer at cell 0.
// Requests arrive on the input channel (valid/stall); one result per request
// leaves on the output channel. total_memory is written over the APB port.
//
// Each pass rotates the whole chain once past the head logic at cell 0, which
// searches, clears owners, merges or repacks entries in flight. Holes left by
// merge and compact are squeezed out by MAX_PARTS rounds of neighbor swaps.
// A final rotation gathers the free-space statistics. Allocate scans, decides,
// edits and gathers (no edit when rejected after the scan); free scans, merges,
// squeezes and gathers (only scan and gather when the owner is absent); compact
// repacks, squeezes, appends and gathers; owner 0 or unknown func only gathers.
// The next request can be taken in the cycle after the result is registered.
// One request is in flight at a time; o_in_stall is high from the cycle after a
// transfer until the result is registered. The result register frees the core,
// so a stalled result only holds the next request at its final cycle.
// Reset, or a write of total_memory, leaves one free partition of the whole
// memory, rewritten in the APB access phase. Reads of total_memory return it.
module variable_partition_allocator_unit #(
    parameter int MAX_PARTS = vpa_pkg::MAX_PARTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  vpa_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output vpa_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import vpa_pkg::*;

    localparam int IW = $clog2(MAX_PARTS);
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam int XW = (CW > CNT_BITS) ? CW : CNT_BITS;
    localparam logic [IW-1:0] LAST = IW'(MAX_PARTS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_EDIT, S_APPLY, S_SQZ, S_APPEND, S_STATS, S_DONE
    } t_state;

    t_state               r_state;
    logic [IW-1:0]        r_k;
    t_in                  r_in;
    t_status              r_status;
    logic                 r_found;
    logic                 r_fit;
    logic [IW-1:0]        r_pick;
    logic [ADDR_BITS-1:0] r_pick_size;
    logic [ADDR_BITS-1:0] r_pick_start;
    logic [ADDR_BITS-1:0] r_acc;
    logic [CW-1:0]        r_w;
    logic [ADDR_BITS-1:0] r_ft;
    logic [CW-1:0]        r_fc;
    logic [ADDR_BITS-1:0] r_lg;
    logic [CW-1:0]        r_pc;
    logic [CW-1:0]        r_used;
    logic [ADDR_BITS-1:0] r_total;
    t_out                 r_out;
    logic                 r_out_valid;

    t_entry        w_q [MAX_PARTS];
    t_entry        w_emit;
    t_entry        w_x;
    t_entry        w_y;
    t_cell_cmd     w_cmd;
    logic [IW-1:0] w_idx;
    logic          w_cfg_wr;
    logic          w_accept;
    logic          w_last;
    logic          w_free_x;
    logic          w_free_y;
    logic          w_cand;
    logic [XW-1:0] w_fc_x;
    logic [XW-1:0] w_pc_x;

    assign w_x      = w_q[0];
    assign w_y      = w_q[1];
    assign w_cfg_wr = psel && penable && pwrite && !paddr[2];
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_last   = (r_k == LAST);
    assign w_free_x = w_x.valid && (w_x.owner == '0 || w_x.owner == r_in.owner);
    assign w_free_y = w_y.valid && (w_y.owner == '0 || w_y.owner == r_in.owner);
    assign w_cand   = w_x.valid && (w_x.owner == '0) && (w_x.size >= r_in.request_size);
    assign w_fc_x   = XW'(r_fc);
    assign w_pc_x   = XW'(r_pc);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign prdata      = {16'h0000, r_total};
    assign pready      = 1'b1;

    // head logic: command for the chain and the entry entering the top cell
    always_comb begin
        w_cmd       = '0;
        w_cmd.op    = OP_HOLD;
        w_idx       = r_pick;
        w_emit      = w_x;
        if (w_cfg_wr) begin
            w_cmd.op    = OP_INIT;
            w_cmd.entry = '{valid: 1'b1, owner: '0, start: '0, size: pwdata[15:0]};
        end else begin
            case (r_state)
                S_SCAN, S_STATS: w_cmd.op = OP_ROT;
                S_APPLY: begin
                    w_cmd.op = OP_ROT;
                    if (r_in.func == FUNC_FREE) begin
                        if (w_x.valid && w_x.owner == r_in.owner) w_emit.owner = '0;
                        if (w_free_x && w_free_y && !w_last) begin
                            // fold this free run into the next entry
                            w_emit.valid      = 1'b0;
                            w_cmd.merge       = 1'b1;
                            w_cmd.merge_start = w_x.start;
                            w_cmd.merge_add   = w_x.size;
                        end
                    end else begin
                        if (w_x.valid && w_x.owner != '0) w_emit.start = r_acc;
                        else                               w_emit.valid = 1'b0;
                    end
                end
                S_SQZ: begin
                    w_cmd.op    = OP_SQZ;
                    w_cmd.phase = r_k[0];
                end
                S_EDIT: begin
                    w_cmd.owner = r_in.owner;
                    w_cmd.size  = r_in.request_size;
                    w_cmd.entry = '{valid: 1'b1, owner: '0,
                                    start: r_pick_start + r_in.request_size,
                                    size:  r_pick_size - r_in.request_size};
                    w_cmd.op    = (r_pick_size != r_in.request_size) ? OP_INS : OP_OWN;
                end
                S_APPEND: begin
                    w_idx       = r_w[IW-1:0];
                    w_cmd.entry = '{valid: 1'b1, owner: '0, start: r_acc,
                                    size: r_total - r_acc};
                    if (r_acc < r_total && r_w < CW'(MAX_PARTS)) w_cmd.op = OP_SET;
                end
                default: w_cmd.op = OP_HOLD;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PARTS; gi++) begin : g_cell
            t_entry w_l;
            t_entry w_r;
            if (gi == 0) begin : g_lo
                assign w_l = '0;
            end else begin : g_lm
                assign w_l = w_q[gi-1];
            end
            if (gi == MAX_PARTS-1) begin : g_hi
                assign w_r = w_emit;
            end else begin : g_hm
                assign w_r = w_q[gi+1];
            end
            vpa_cell #(.MAX_PARTS(MAX_PARTS), .IDX(gi), .IW(IW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_idx   (w_idx),
                .i_left  (w_l),
                .i_right (w_r),
                .o_q     (w_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_used      <= CW'(1);
            r_total     <= TOTAL_RESET;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) r_out_valid <= 1'b0;
            if (w_cfg_wr) begin
                r_total <= pwdata[15:0];
                r_used  <= CW'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in     <= i_in_data;
                        r_k      <= '0;
                        r_found  <= 1'b0;
                        r_fit    <= 1'b0;
                        r_acc    <= '0;
                        r_w      <= '0;
                        r_ft     <= '0;
                        r_fc     <= '0;
                        r_lg     <= '0;
                        r_pc     <= '0;
                        case (i_in_data.func)
                            FUNC_ALLOC, FUNC_FREE: begin
                                if (i_in_data.owner == '0) begin
                                    r_status <= ST_BAD_OWNER;
                                    r_state  <= S_STATS;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_SCAN;
                                end
                            end
                            FUNC_COMPACT: begin
                                r_status <= ST_OK;
                                r_state  <= S_APPLY;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_STATS;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_x.valid && w_x.owner == r_in.owner) r_found <= 1'b1;
                    if (w_cand) begin
                        if (!r_fit ||
                            (r_in.strategy == FIT_BEST && w_x.size < r_pick_size) ||
                            (r_in.strategy == FIT_WORST && w_x.size > r_pick_size)) begin
                            r_fit        <= 1'b1;
                            r_pick       <= r_k;
                            r_pick_size  <= w_x.size;
                            r_pick_start <= w_x.start;
                        end
                    end
                    if (w_last) begin
                        r_k     <= '0;
                        r_state <= S_DECIDE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DECIDE: begin
                    if (r_in.func == FUNC_FREE) begin
                        if (!r_found) begin
                            r_status <= ST_NOT_FOUND;
                            r_state  <= S_STATS;
                        end else begin
                            r_state <= S_APPLY;
                        end
                    end else if (r_found) begin
                        r_status <= ST_OWNER_EXISTS;
                        r_state  <= S_STATS;
                    end else if (r_in.request_size == '0) begin
                        r_status <= ST_BAD_SIZE;
                        r_state  <= S_STATS;
                    end else if (r_in.strategy > FIT_WORST || !r_fit) begin
                        r_status <= ST_NO_FIT;
                        r_state  <= S_STATS;
                    end else if (r_pick_size != r_in.request_size &&
                                 r_used >= CW'(MAX_PARTS)) begin
                        r_status <= ST_TABLE_FULL;
                        r_state  <= S_STATS;
                    end else begin
                        r_state <= S_EDIT;
                    end
                end
                S_EDIT: r_state <= S_STATS;
                S_APPLY: begin
                    if (w_x.valid && w_x.owner != '0) begin
                        r_acc <= r_acc + w_x.size;
                        r_w   <= r_w + 1'b1;
                    end
                    if (w_last) begin
                        r_k     <= '0;
                        r_state <= S_SQZ;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SQZ: begin
                    if (w_last) begin
                        r_k     <= '0;
                        r_state <= (r_in.func == FUNC_COMPACT) ? S_APPEND : S_STATS;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_APPEND: r_state <= S_STATS;
                S_STATS: begin
                    if (w_x.valid) begin
                        r_pc <= r_pc + 1'b1;
                        if (w_x.owner == '0) begin
                            r_ft <= r_ft + w_x.size;
                            r_fc <= r_fc + 1'b1;
                            if (w_x.size > r_lg) r_lg <= w_x.size;
                        end
                    end
                    if (w_last) begin
                        r_k     <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DONE: begin
                    // wait here only while an older result is still held
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.status          <= r_status;
                        r_out.alloc_start     <= (r_status == ST_OK && r_in.func == FUNC_ALLOC)
                                                 ? r_pick_start : '0;
                        r_out.free_total      <= r_ft;
                        r_out.free_count      <= w_fc_x[CNT_BITS-1:0];
                        r_out.largest_free    <= r_lg;
                        r_out.partition_count <= w_pc_x[CNT_BITS-1:0];
                        r_out_valid           <= 1'b1;
                        r_used                <= r_pc;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/vpa_checker.sv]
// Port-level checks for the partition allocator, bound to the top level.
// Depends on vpa_pkg and variable_partition_allocator_unit.
module vpa_port_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input vpa_pkg::t_out o_out_data
);
    import vpa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while one is in flight");

    a_start_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.alloc_start == '0)
        else $error("alloc_start set on a failed request");

    a_free_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.free_count <= o_out_data.partition_count)
        else $error("more free partitions than entries");

endmodule

bind variable_partition_allocator_unit vpa_port_checker u_vpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[sim/vpa_checker.sv]
// Result checker for the variable partition allocator: tracks the partition table,
// predicts one result per request transfer and compares it with the output channel.
// Depends on vpa_pkg.
module vpa_checker
    import vpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out_data,
    input  logic        i_cfg_wr,
    input  logic [15:0] i_cfg_total,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPART = MAX_PARTS_DEF;

    logic [7:0]  tbl_owner [NPART];
    logic [15:0] tbl_start [NPART];
    logic [15:0] tbl_size  [NPART];
    int          tbl_used;
    logic [15:0] mem_total;
    t_out        expected_results [$];

    assign o_pending = expected_results.size();

    function automatic void table_init(input logic [15:0] total);
        for (int k = 0; k < NPART; k++) begin
            tbl_owner[k] = '0;
            tbl_start[k] = '0;
            tbl_size[k]  = '0;
        end
        mem_total    = total;
        tbl_size[0]  = total;
        tbl_used     = 1;
    endfunction

    function automatic void drop_entry(input int k);
        for (int j = k; j + 1 < tbl_used; j++) begin
            tbl_owner[j] = tbl_owner[j+1];
            tbl_start[j] = tbl_start[j+1];
            tbl_size[j]  = tbl_size[j+1];
        end
        tbl_used--;
    endfunction

    function automatic t_status allocate(input logic [7:0] who, input logic [15:0] req,
                                         input logic [1:0] fit, output logic [15:0] base);
        int pick;
        bit found;
        pick  = 0;
        found = 0;
        base  = '0;
        if (who == 0) return ST_BAD_OWNER;
        for (int k = 0; k < tbl_used; k++)
            if (tbl_owner[k] == who) return ST_OWNER_EXISTS;
        if (req == 0) return ST_BAD_SIZE;
        if (fit > FIT_WORST) return ST_NO_FIT;
        for (int k = 0; k < tbl_used; k++) begin
            if (tbl_owner[k] != 0 || tbl_size[k] < req) continue;
            if (!found) begin
                pick  = k;
                found = 1;
                if (fit == FIT_FIRST) break;
            end else if (fit == FIT_BEST && tbl_size[k] < tbl_size[pick]) begin
                pick = k;
            end else if (fit == FIT_WORST && tbl_size[k] > tbl_size[pick]) begin
                pick = k;
            end
        end
        if (!found) return ST_NO_FIT;
        if (tbl_size[pick] != req) begin
            if (tbl_used >= NPART) return ST_TABLE_FULL;
            for (int j = tbl_used; j > pick + 1; j--) begin
                tbl_owner[j] = tbl_owner[j-1];
                tbl_start[j] = tbl_start[j-1];
                tbl_size[j]  = tbl_size[j-1];
            end
            tbl_owner[pick+1] = '0;
            tbl_start[pick+1] = tbl_start[pick] + req;
            tbl_size[pick+1]  = tbl_size[pick] - req;
            tbl_size[pick]    = req;
            tbl_used++;
        end
        tbl_owner[pick] = who;
        base = tbl_start[pick];
        return ST_OK;
    endfunction

    function automatic t_status release_owner(input logic [7:0] who);
        bit hit;
        int k;
        hit = 0;
        if (who == 0) return ST_BAD_OWNER;
        for (k = 0; k < tbl_used; k++)
            if (tbl_owner[k] == who) begin
                tbl_owner[k] = '0;
                hit = 1;
            end
        if (!hit) return ST_NOT_FOUND;
        k = 0;
        while (k + 1 < tbl_used) begin
            if (tbl_owner[k] == 0 && tbl_owner[k+1] == 0) begin
                tbl_size[k] = tbl_size[k] + tbl_size[k+1];
                drop_entry(k + 1);
            end else begin
                k++;
            end
        end
        return ST_OK;
    endfunction

    function automatic void compact_table();
        int          w;
        logic [15:0] used;
        w    = 0;
        used = '0;
        for (int k = 0; k < tbl_used; k++)
            if (tbl_owner[k] != 0) begin
                tbl_owner[w] = tbl_owner[k];
                tbl_size[w]  = tbl_size[k];
                tbl_start[w] = used;
                used = used + tbl_size[k];
                w++;
            end
        if (used < mem_total && w < NPART) begin
            tbl_owner[w] = '0;
            tbl_start[w] = used;
            tbl_size[w]  = mem_total - used;
            w++;
        end
        tbl_used = w;
    endfunction

    function automatic t_out predict_result(input t_in req);
        t_out        r;
        logic [15:0] base;
        logic [31:0] ftot;
        r      = '0;
        base   = '0;
        ftot   = 0;
        r.status = ST_OK;
        case (req.func)
            FUNC_ALLOC: begin
                r.status = allocate(req.owner, req.request_size, req.strategy, base);
                if (r.status == ST_OK) r.alloc_start = base;
            end
            FUNC_FREE: r.status = release_owner(req.owner);
            FUNC_COMPACT: compact_table();
            default: ;
        endcase
        for (int k = 0; k < tbl_used; k++)
            if (tbl_owner[k] == 0) begin
                ftot = ftot + 32'(tbl_size[k]);
                r.free_count = r.free_count + 1'b1;
                if (tbl_size[k] > r.largest_free) r.largest_free = tbl_size[k];
            end
        r.free_total      = ftot[15:0];
        r.partition_count = tbl_used[6:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            table_init(TOTAL_RESET);
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_wr) table_init(i_cfg_total);
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: %p", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want,
                                 i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) expected_results.push_back(predict_result(i_in_data));
        end
    end
endmodule

[sim/variable_partition_allocator_unit_tb.sv]
// Top of the allocator testbench: clock, reset, APB writes of total_memory and
// request stimulus with random gaps and output stalls. Uses vpa_pkg, vpa_checker.
module variable_partition_allocator_unit_tb;
    import vpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = 4 * MAX_PARTS_DEF + 20;
    localparam int LIMIT  = 2000000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    t_out        out_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    int          cycles = 0;
    bit          hold_off = 0;

    variable_partition_allocator_unit DUT (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    vpa_checker u_chk (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_wr(psel && penable && pwrite && pready), .i_cfg_total(pwdata[15:0]),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("variable_partition_allocator_unit verification failed");
            $finish;
        end
    end

    // receiver: random wait before each result, long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_stall <= 1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
                out_stall <= 0;
            end else if (out_valid && !out_stall) begin
                // transfer at this edge: hold the next result for a random wait
                n = $urandom_range(0, 10);
                if (n > 0) begin
                    out_stall <= 1;
                    do @(posedge i_clk); while (!out_valid);
                    repeat (n) @(posedge i_clk);
                    out_stall <= 0;
                end
            end
        end
    end

    task automatic write_total(input logic [15:0] total);
        in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= {16'd0, total};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    task automatic send(input logic [1:0] fn, input logic [7:0] who,
                        input logic [15:0] sz, input logic [1:0] fit, input bit gaps);
        int g;
        g = gaps ? $urandom_range(0, 10) : 0;
        if ($urandom_range(0, 2) == 0) g = 0;
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1;
        in_data  <= '{func: fn, owner: who, request_size: sz, strategy: fit};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count, input logic [15:0] total);
        logic [1:0]  fn;
        logic [7:0]  who;
        logic [15:0] sz;
        int          r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            fn  = r < 60 ? FUNC_ALLOC : r < 90 ? FUNC_FREE : r < 97 ? FUNC_COMPACT : 2'd3;
            who = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(1, 40));
            if ($urandom_range(0, 4) == 0) sz = 16'($urandom);
            else sz = 16'($urandom_range(1, total / 8 + 1));
            send(fn, who, sz, $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                 1);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: checks, fits, exact fit, free merge, compact, unknown codes
        send(FUNC_ALLOC, 8'd0, 16'd5, FIT_FIRST, 0);
        send(FUNC_ALLOC, 8'd1, 16'd0, FIT_FIRST, 0);
        send(FUNC_ALLOC, 8'd1, 16'd100, FIT_FIRST, 0);
        send(FUNC_ALLOC, 8'd1, 16'd7, FIT_FIRST, 0);
        send(FUNC_ALLOC, 8'd2, 16'd300, FIT_BEST, 0);
        send(FUNC_ALLOC, 8'd255, 16'd50, FIT_WORST, 0);
        send(FUNC_ALLOC, 8'd3, 16'd10, 2'd3, 0);
        send(FUNC_ALLOC, 8'd4, 16'hFFFF, FIT_FIRST, 0);
        send(FUNC_FREE, 8'd0, 16'hFFFF, 2'd3, 0);
        send(FUNC_FREE, 8'd77, 16'd0, FIT_FIRST, 0);
        send(FUNC_FREE, 8'd1, 16'd0, FIT_FIRST, 0);
        send(FUNC_ALLOC, 8'd5, 16'd100, FIT_BEST, 0);
        send(FUNC_COMPACT, 8'd0, 16'd0, FIT_FIRST, 0);
        send(2'd3, 8'd9, 16'd9, FIT_FIRST, 0);
        send(FUNC_FREE, 8'd255, 16'd0, FIT_FIRST, 0);
        send(FUNC_ALLOC, 8'd6, 16'hFFFF, FIT_WORST, 0);
        write_total(16'd0);
        send(FUNC_ALLOC, 8'd1, 16'd1, FIT_FIRST, 0);
        send(FUNC_COMPACT, 8'd0, 16'd0, FIT_FIRST, 0);
        write_total(16'd1);
        send(FUNC_ALLOC, 8'd1, 16'd1, FIT_FIRST, 0);
        send(FUNC_COMPACT, 8'd0, 16'd0, FIT_FIRST, 0);
        // small memory with many single-unit grants fills the table
        write_total(16'd200);
        for (int k = 1; k <= 66; k++) send(FUNC_ALLOC, 8'(k), 16'd1, FIT_FIRST, 1);
        send(FUNC_ALLOC, 8'd200, 16'($urandom_range(2, 100)), FIT_BEST, 0);
        random_phase(120, 16'd200);
        // queue requests behind a held result while the receiver holds off
        hold_off = 1;
        random_phase(30, 16'd200);
        write_total(16'hFFFF);
        random_phase(80, 16'hFFFF);
        write_total(16'd1000);
        random_phase(80, 16'd1000);
        in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("variable_partition_allocator_unit verification clean");
        end else begin
            $display("variable_partition_allocator_unit verification failed");
        end
        $finish;
    end
endmodule

[sim.f]
hdl/vpa_pkg.sv
hdl/vpa_cell.sv
hdl/variable_partition_allocator_unit.sv
hdl/vpa_checker.sv
sim/vpa_checker.sv
sim/variable_partition_allocator_unit_tb.sv
